FILE: hw/rtl/atb_pkg.sv
// Shared types and constants for the affine transform bounding box block.
package atb_pkg;

	// Fixed-point format of coordinates and coefficients.
	localparam int Q_W      = 32;
	localparam int Q_FRAC   = 16;
	localparam int PROD_W   = 2 * Q_W;
	localparam int TERM_W   = PROD_W - Q_FRAC;
	localparam int SUM_W    = TERM_W + 2;
	localparam int NUM_ROWS = 3;

	// Configuration port geometry.
	localparam int NUM_REGS   = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_LIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_ZT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_LIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_ZT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_LIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_ZT  = 3'd5;

	// Reset values give the identity matrix.
	localparam logic [CFG_DATA_W-1:0] RST_ROW0_LIN = 64'h0000_0000_0001_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW0_ZT  = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW1_LIN = 64'h0001_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW1_ZT  = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW2_LIN = 64'h0000_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ROW2_ZT  = 64'h0000_0000_0001_0000;

	// Saturation limits.
	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef logic signed [Q_W-1:0] q16_t;
	typedef logic signed [TERM_W-1:0] term_t;

	// Input word.
	typedef struct packed {
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic               last_vertex;
	} vert_t;

	// Result word.
	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
		logic               box_done;
	} res_t;

	// One matrix row: three linear terms and a translation.
	typedef struct packed {
		q16_t a;
		q16_t b;
		q16_t c;
		q16_t t;
	} row_coef_t;

	typedef row_coef_t [NUM_ROWS-1:0] mat_t;

	// Shifted products of one row.
	typedef struct packed {
		term_t term_a;
		term_t term_b;
		term_t term_c;
	} row_prod_t;

	typedef struct packed {
		row_prod_t [NUM_ROWS-1:0] row;
		logic                     last;
	} prod_t;

	// Transformed point.
	typedef struct packed {
		q16_t x;
		q16_t y;
		q16_t z;
		logic last;
	} pt_t;

	// Stage load enables.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_out;
	} pipe_ctl_t;

endpackage

FILE: hw/rtl/atb_if.sv
// Stream interfaces for vertex words and result words.
interface atb_vert_if;
	logic           valid;
	logic           ready;
	atb_pkg::vert_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface atb_res_if;
	logic          valid;
	logic          ready;
	atb_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/atb_mult.sv
// Multiply stage: nine coefficient products, each shifted down by the fraction width.
module atb_mult (
	input  logic               clk,
	input  atb_pkg::pipe_ctl_t ctl,
	input  atb_pkg::mat_t      mat,
	input  atb_pkg::vert_t     vert_s1,
	output atb_pkg::prod_t     prod_s2
);

	atb_pkg::prod_t prod_d;

	// Each row multiplies its coefficients by the vertex; full 64-bit products.
	for (genvar r = 0; r < atb_pkg::NUM_ROWS; r++) begin : g_row
		logic signed [atb_pkg::PROD_W-1:0] pa;
		logic signed [atb_pkg::PROD_W-1:0] pb;
		logic signed [atb_pkg::PROD_W-1:0] pc;

		assign pa = atb_pkg::PROD_W'($signed(mat[r].a))
			* atb_pkg::PROD_W'($signed(vert_s1.vert_x));
		assign pb = atb_pkg::PROD_W'($signed(mat[r].b))
			* atb_pkg::PROD_W'($signed(vert_s1.vert_y));
		assign pc = atb_pkg::PROD_W'($signed(mat[r].c))
			* atb_pkg::PROD_W'($signed(vert_s1.vert_z));

		// Dropping the low bits is an arithmetic shift, rounding toward minus infinity.
		assign prod_d.row[r].term_a = pa[atb_pkg::PROD_W-1:atb_pkg::Q_FRAC];
		assign prod_d.row[r].term_b = pb[atb_pkg::PROD_W-1:atb_pkg::Q_FRAC];
		assign prod_d.row[r].term_c = pc[atb_pkg::PROD_W-1:atb_pkg::Q_FRAC];
	end

	assign prod_d.last = vert_s1.last_vertex;

	// Product register.
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			prod_s2 <= prod_d;
		end
	end

endmodule

FILE: hw/rtl/atb_sum.sv
// Sum stage: adds the shifted products and translation per row, then saturates.
module atb_sum (
	input  logic               clk,
	input  atb_pkg::pipe_ctl_t ctl,
	input  atb_pkg::mat_t      mat,
	input  atb_pkg::prod_t     prod_s2,
	output atb_pkg::pt_t       pt_s3
);

	atb_pkg::q16_t [atb_pkg::NUM_ROWS-1:0] sat_d;
	atb_pkg::pt_t                          pt_d;

	// Clamp a wide sum to the signed 32-bit range.
	function automatic atb_pkg::q16_t sat32(input logic signed [atb_pkg::SUM_W-1:0] s);
		atb_pkg::q16_t v;
		if (s[atb_pkg::SUM_W-1:atb_pkg::Q_W-1] == '0
			|| s[atb_pkg::SUM_W-1:atb_pkg::Q_W-1] == '1) begin
			v = s[atb_pkg::Q_W-1:0];
		end else if (s[atb_pkg::SUM_W-1]) begin
			v = atb_pkg::Q_MIN;
		end else begin
			v = atb_pkg::Q_MAX;
		end
		return v;
	endfunction

	// The sum is exact at this width, so saturation happens once at the end.
	for (genvar r = 0; r < atb_pkg::NUM_ROWS; r++) begin : g_row
		logic signed [atb_pkg::SUM_W-1:0] sum;

		assign sum = atb_pkg::SUM_W'(prod_s2.row[r].term_a)
			+ atb_pkg::SUM_W'(prod_s2.row[r].term_b)
			+ atb_pkg::SUM_W'(prod_s2.row[r].term_c)
			+ atb_pkg::SUM_W'(mat[r].t);
		assign sat_d[r] = sat32(sum);
	end

	assign pt_d.x    = sat_d[0];
	assign pt_d.y    = sat_d[1];
	assign pt_d.z    = sat_d[2];
	assign pt_d.last = prod_s2.last;

	// Point register.
	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			pt_s3 <= pt_d;
		end
	end

endmodule

FILE: hw/rtl/atb_box.sv
// Box stage: running per-axis min and max, held in the result register.
module atb_box (
	input  logic               clk,
	input  logic               arst_n,
	input  atb_pkg::pipe_ctl_t ctl,
	input  atb_pkg::pt_t       pt_s3,
	output atb_pkg::res_t      res_q
);

	logic          run_start_q;
	atb_pkg::res_t res_d;

	// The first point of a run seeds the box; later ones widen it.
	always_comb begin
		res_d.out_x    = pt_s3.x;
		res_d.out_y    = pt_s3.y;
		res_d.out_z    = pt_s3.z;
		res_d.box_done = pt_s3.last;
		if (run_start_q) begin
			res_d.box_min_x = pt_s3.x;
			res_d.box_min_y = pt_s3.y;
			res_d.box_min_z = pt_s3.z;
			res_d.box_max_x = pt_s3.x;
			res_d.box_max_y = pt_s3.y;
			res_d.box_max_z = pt_s3.z;
		end else begin
			res_d.box_min_x = (pt_s3.x < res_q.box_min_x) ? pt_s3.x : res_q.box_min_x;
			res_d.box_min_y = (pt_s3.y < res_q.box_min_y) ? pt_s3.y : res_q.box_min_y;
			res_d.box_min_z = (pt_s3.z < res_q.box_min_z) ? pt_s3.z : res_q.box_min_z;
			res_d.box_max_x = (pt_s3.x > res_q.box_max_x) ? pt_s3.x : res_q.box_max_x;
			res_d.box_max_y = (pt_s3.y > res_q.box_max_y) ? pt_s3.y : res_q.box_max_y;
			res_d.box_max_z = (pt_s3.z > res_q.box_max_z) ? pt_s3.z : res_q.box_max_z;
		end
	end

	// Run tracking: the word after a last vertex starts a new box.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= 1'b1;
		end else if (ctl.ld_out) begin
			run_start_q <= pt_s3.last;
		end
	end

	// Result register, which also holds the box state between words.
	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			res_q <= res_d;
		end
	end

endmodule

FILE: hw/rtl/affine_transform_bounding_box.sv
// Top level of the affine transform bounding box block.
//
//   port   direction  word     contents
//   vtx    in         vert_t   vertex x, y, z in Q16.16 and last-vertex flag
//   res    out        res_t    transformed point, running box, box-done flag
//   cfg_*  in         64 bits  matrix row registers, written by index
//
// One word per cycle is sustained while results are taken; a result is offered
// once its vertex, taken into the input register, has passed the multiply, sum
// and result registers.
// Reset restores the identity matrix and makes the next vertex seed a box.
// Each stage moves when the one after it is empty or moving, so bubbles
// close up while the result waits and the input stalls only when all are full.
module affine_transform_bounding_box (
	input  logic                               clk,
	input  logic                               arst_n,
	atb_vert_if.sink                           vtx,
	atb_res_if.source                          res,
	input  logic                               cfg_we,
	input  logic [atb_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [atb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [atb_pkg::CFG_DATA_W-1:0] row0_lin_q;
	logic [atb_pkg::CFG_DATA_W-1:0] row0_zt_q;
	logic [atb_pkg::CFG_DATA_W-1:0] row1_lin_q;
	logic [atb_pkg::CFG_DATA_W-1:0] row1_zt_q;
	logic [atb_pkg::CFG_DATA_W-1:0] row2_lin_q;
	logic [atb_pkg::CFG_DATA_W-1:0] row2_zt_q;
	atb_pkg::mat_t                  mat;

	logic               v1_q, v2_q, v3_q, vo_q;
	logic               rdy1, rdy2, rdy3, rdyo;
	logic               ld_s1;
	atb_pkg::pipe_ctl_t ctl;

	atb_pkg::vert_t vert_s1;
	atb_pkg::prod_t prod_s2;
	atb_pkg::pt_t   pt_s3;
	atb_pkg::res_t  res_word;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_lin_q <= atb_pkg::RST_ROW0_LIN;
			row0_zt_q  <= atb_pkg::RST_ROW0_ZT;
			row1_lin_q <= atb_pkg::RST_ROW1_LIN;
			row1_zt_q  <= atb_pkg::RST_ROW1_ZT;
			row2_lin_q <= atb_pkg::RST_ROW2_LIN;
			row2_zt_q  <= atb_pkg::RST_ROW2_ZT;
		end else if (cfg_we) begin
			case (cfg_idx)
				atb_pkg::REG_ROW0_LIN: row0_lin_q <= cfg_data;
				atb_pkg::REG_ROW0_ZT:  row0_zt_q  <= cfg_data;
				atb_pkg::REG_ROW1_LIN: row1_lin_q <= cfg_data;
				atb_pkg::REG_ROW1_ZT:  row1_zt_q  <= cfg_data;
				atb_pkg::REG_ROW2_LIN: row2_lin_q <= cfg_data;
				atb_pkg::REG_ROW2_ZT:  row2_zt_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the coefficient halves into matrix rows.
	assign mat[0] = '{a: row0_lin_q[31:0], b: row0_lin_q[63:32],
		c: row0_zt_q[31:0], t: row0_zt_q[63:32]};
	assign mat[1] = '{a: row1_lin_q[31:0], b: row1_lin_q[63:32],
		c: row1_zt_q[31:0], t: row1_zt_q[63:32]};
	assign mat[2] = '{a: row2_lin_q[31:0], b: row2_lin_q[63:32],
		c: row2_zt_q[31:0], t: row2_zt_q[63:32]};

	// Stage ready chain: a stage can load when it is empty or drains this cycle.
	assign rdyo = !vo_q || res.ready;
	assign rdy3 = !v3_q || rdyo;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;

	assign ld_s1      = vtx.valid && rdy1;
	assign ctl.ld_s2  = v1_q && rdy2;
	assign ctl.ld_s3  = v2_q && rdy3;
	assign ctl.ld_out = v3_q && rdyo;

	assign vtx.ready = rdy1;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			v1_q <= ld_s1 || (v1_q && !rdy2);
			v2_q <= ctl.ld_s2 || (v2_q && !rdy3);
			v3_q <= ctl.ld_s3 || (v3_q && !rdyo);
			vo_q <= ctl.ld_out || (vo_q && !res.ready);
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			vert_s1 <= vtx.data;
		end
	end

	atb_mult u_mult (
		.clk     (clk),
		.ctl     (ctl),
		.mat     (mat),
		.vert_s1 (vert_s1),
		.prod_s2 (prod_s2)
	);

	atb_sum u_sum (
		.clk     (clk),
		.ctl     (ctl),
		.mat     (mat),
		.prod_s2 (prod_s2),
		.pt_s3   (pt_s3)
	);

	atb_box u_box (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pt_s3  (pt_s3),
		.res_q  (res_word)
	);

	assign res.valid = vo_q;
	assign res.data  = res_word;

`ifndef SYNTHESIS
	// A shown point always lies inside the box shown with it.
	a_point_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ($signed(res.data.box_min_x) <= $signed(res.data.out_x)
			&& $signed(res.data.out_x) <= $signed(res.data.box_max_x)
			&& $signed(res.data.box_min_y) <= $signed(res.data.out_y)
			&& $signed(res.data.out_y) <= $signed(res.data.box_max_y)
			&& $signed(res.data.box_min_z) <= $signed(res.data.out_z)
			&& $signed(res.data.out_z) <= $signed(res.data.box_max_z)))
		else $error("result point outside its bounding box");

	// The input stalls only when every stage holds a word.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!vtx.ready |-> (v1_q && v2_q && v3_q && vo_q))
		else $error("input stalled with an empty stage");

	// The result register never overwrites a word that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.ld_out && vo_q && !res.ready))
		else $error("result word overwritten before it was taken");
`endif

endmodule
